FILE: hdl/i2cms_pkg.sv
// types and constants shared by the i2c master bit sequencer
package i2cms_pkg;

    localparam logic [2:0] FUNC_START    = 3'd0;
    localparam logic [2:0] FUNC_STOP     = 3'd1;
    localparam logic [2:0] FUNC_WRITE    = 3'd2;
    localparam logic [2:0] FUNC_READ     = 3'd3;
    localparam logic [2:0] FUNC_WAIT_ACK = 3'd4;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNIT_TICKS     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACK_POLL_LIMIT = 8'd1;

    localparam logic [15:0] UNIT_TICKS_RESET     = 16'd1;
    localparam logic [7:0]  ACK_POLL_LIMIT_RESET = 8'd250;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] func;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_error;
    } t_out_item;

    typedef struct packed {
        logic [15:0] unit_ticks;
        logic [7:0]  ack_poll_limit;
    } t_cfg;

endpackage

FILE: hdl/i2cms_seq.sv
// bus phase sequencer: holds pin and phase state, steps once per tick
module i2cms_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  i2cms_pkg::t_in_item i_item,
    input  i2cms_pkg::t_cfg     i_cfg,
    output i2cms_pkg::t_out_item o_res
);

    typedef enum logic [4:0] {
        S_IDLE, S_ST_A, S_ST_B,
        S_SP_A, S_SP_B, S_SP_C, S_SP_CHK, S_SP_PLO, S_SP_PHI, S_SP_PSD, S_SP_TAIL,
        S_WB_SET, S_WB_HI, S_WB_LO,
        S_RB_LO, S_RB_HI, S_AK_LO, S_AK_SD, S_AK_HI, S_NK_LO, S_NK_HI,
        S_WA_SD, S_WA_HI, S_WA_POLL
    } t_state;

    t_state      r_state, n_state;
    logic [17:0] r_delay, n_delay;
    logic [3:0]  r_bit, n_bit;
    logic [7:0]  r_shift, n_shift;
    logic [7:0]  r_poll, n_poll;
    logic        r_ack, n_ack;
    logic        r_err, n_err;
    logic [7:0]  r_rx, n_rx;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic        r_drv, n_drv;
    logic        n_done;

    logic [15:0] w_unit;
    logic [17:0] w_d1, w_d2, w_d4;
    logic [3:0]  w_bit_inc;
    logic [7:0]  w_poll_cur;

    // a zero unit count behaves as one tick per unit
    assign w_unit    = (i_cfg.unit_ticks == 16'd0) ? 16'd1 : i_cfg.unit_ticks;
    assign w_d1      = {2'b00, w_unit} - 18'd1;
    assign w_d2      = {1'b0, w_unit, 1'b0} - 18'd1;
    assign w_d4      = {w_unit, 2'b00} - 18'd1;
    assign w_bit_inc = r_bit + 4'd1;
    assign w_poll_cur = (r_state == S_WA_HI) ? 8'd0 : r_poll;

    always_comb begin
        n_state = r_state;
        n_delay = r_delay;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_poll  = r_poll;
        n_ack   = r_ack;
        n_err   = r_err;
        n_rx    = r_rx;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_drv   = r_drv;
        n_done  = 1'b0;
        if (r_state == S_IDLE) begin
            if (i_item.cmd_valid) begin
                case (i_item.func)
                    i2cms_pkg::FUNC_START: begin
                        n_drv = 1'b1; n_sda = 1'b1; n_scl = 1'b1;
                        n_state = S_ST_A; n_delay = w_d4;
                    end
                    i2cms_pkg::FUNC_STOP: begin
                        n_drv = 1'b1; n_scl = 1'b0;
                        n_state = S_SP_A; n_delay = w_d2;
                    end
                    i2cms_pkg::FUNC_WRITE: begin
                        n_shift = i_item.tx_byte;
                        n_bit = 4'd0;
                        n_drv = 1'b1; n_scl = 1'b0;
                        n_sda = i_item.tx_byte[7];
                        n_state = S_WB_SET; n_delay = w_d2;
                    end
                    i2cms_pkg::FUNC_READ: begin
                        n_shift = 8'd0;
                        n_bit = 4'd0;
                        n_ack = i_item.send_ack;
                        n_drv = 1'b0; n_scl = 1'b0;
                        n_state = S_RB_LO; n_delay = w_d2;
                    end
                    i2cms_pkg::FUNC_WAIT_ACK: begin
                        n_drv = 1'b0; n_sda = 1'b1;
                        n_state = S_WA_SD; n_delay = w_d1;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
        end else if (r_delay != 18'd0) begin
            n_delay = r_delay - 18'd1;
        end else begin
            case (r_state)
                S_ST_A: begin n_sda = 1'b0; n_state = S_ST_B; n_delay = w_d4; end
                S_ST_B: begin n_scl = 1'b0; n_state = S_IDLE; n_delay = '0; n_done = 1'b1; end

                S_SP_A: begin n_sda = 1'b0; n_state = S_SP_B; n_delay = w_d4; end
                S_SP_B: begin n_scl = 1'b1; n_state = S_SP_C; n_delay = w_d2; end
                S_SP_C: begin n_sda = 1'b1; n_state = S_SP_CHK; n_delay = '0; end
                S_SP_CHK: begin
                    // slave still holding sda low: clock it out
                    if (!i_item.sda_in) begin
                        n_scl = 1'b0; n_state = S_SP_PLO; n_delay = '0;
                    end else begin
                        n_state = S_SP_TAIL; n_delay = w_d4;
                    end
                end
                S_SP_PLO: begin n_scl = 1'b1; n_state = S_SP_PHI; n_delay = w_d1; end
                S_SP_PHI: begin n_sda = 1'b1; n_state = S_SP_PSD; n_delay = w_d1; end
                S_SP_PSD: begin n_state = S_SP_CHK; n_delay = '0; end
                S_SP_TAIL: begin n_state = S_IDLE; n_delay = '0; n_done = 1'b1; end

                S_WB_SET: begin n_scl = 1'b1; n_state = S_WB_HI; n_delay = w_d2; end
                S_WB_HI: begin n_scl = 1'b0; n_state = S_WB_LO; n_delay = w_d2; end
                S_WB_LO: begin
                    n_bit = w_bit_inc;
                    n_shift = {r_shift[6:0], 1'b0};
                    if (w_bit_inc < 4'd8) begin
                        n_sda = r_shift[6];
                        n_state = S_WB_SET; n_delay = w_d2;
                    end else begin
                        n_state = S_IDLE; n_delay = '0; n_done = 1'b1;
                    end
                end

                S_RB_LO: begin
                    n_scl = 1'b1;
                    n_shift = {r_shift[6:0], i_item.sda_in};
                    n_state = S_RB_HI; n_delay = w_d1;
                end
                S_RB_HI: begin
                    n_bit = w_bit_inc;
                    n_scl = 1'b0;
                    if (w_bit_inc < 4'd8) begin
                        n_state = S_RB_LO; n_delay = w_d2;
                    end else begin
                        n_rx = r_shift;
                        n_drv = 1'b1;
                        n_delay = w_d2;
                        if (r_ack) begin
                            n_state = S_AK_LO;
                        end else begin
                            n_sda = 1'b1;
                            n_state = S_NK_LO;
                        end
                    end
                end
                S_AK_LO: begin n_sda = 1'b0; n_state = S_AK_SD; n_delay = w_d2; end
                S_AK_SD: begin n_scl = 1'b1; n_state = S_AK_HI; n_delay = w_d2; end
                S_AK_HI: begin n_scl = 1'b0; n_state = S_IDLE; n_delay = '0; n_done = 1'b1; end
                S_NK_LO: begin n_scl = 1'b1; n_state = S_NK_HI; n_delay = w_d2; end
                S_NK_HI: begin n_scl = 1'b0; n_state = S_IDLE; n_delay = '0; n_done = 1'b1; end

                S_WA_SD: begin n_scl = 1'b1; n_state = S_WA_HI; n_delay = w_d1; end
                S_WA_HI, S_WA_POLL: begin
                    n_poll = w_poll_cur;
                    if (!i_item.sda_in) begin
                        n_scl = 1'b0; n_err = 1'b0;
                        n_state = S_IDLE; n_delay = '0; n_done = 1'b1;
                    end else if (w_poll_cur >= i_cfg.ack_poll_limit) begin
                        // timeout: flag it and release the bus with a stop
                        n_err = 1'b1;
                        n_drv = 1'b1; n_scl = 1'b0;
                        n_state = S_SP_A; n_delay = w_d2;
                    end else begin
                        n_poll = w_poll_cur + 8'd1;
                        n_state = S_WA_POLL; n_delay = '0;
                    end
                end

                default: begin n_state = S_IDLE; n_delay = '0; n_done = 1'b1; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_delay <= '0;
            r_bit   <= '0;
            r_shift <= '0;
            r_poll  <= '0;
            r_ack   <= 1'b0;
            r_err   <= 1'b0;
            r_rx    <= '0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_drv   <= 1'b1;
        end else if (i_step) begin
            r_state <= n_state;
            r_delay <= n_delay;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_poll  <= n_poll;
            r_ack   <= n_ack;
            r_err   <= n_err;
            r_rx    <= n_rx;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_drv   <= n_drv;
        end
    end

    always_comb begin
        o_res.scl       = n_scl;
        o_res.sda_out   = n_sda;
        o_res.sda_drive = n_drv;
        o_res.busy_res  = (n_state != S_IDLE);
        o_res.done_res  = n_done;
        o_res.rx_byte   = n_rx;
        o_res.ack_error = n_err;
    end

endmodule

FILE: hdl/i2c_master_bit_sequencer_core.sv
// top level: item handshake, configuration registers and result register
// I2C master bit sequencer. Each accepted input item is one bus tick; the block
// takes one item every clock while the output is not stalled and returns exactly
// one result item per input item, through the input register and then the result
// register. The input register feeds the phase update (pins, delay counter, shift
// and poll state), whose outcome is captured in the result register; a stall on
// the result side holds the pipeline and backs up to the input stall.
// Configuration writes are always ready: index 0 sets unit_ticks, index 1 sets
// ack_poll_limit, other indexes are ignored.
module i2c_master_bit_sequencer_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  i2cms_pkg::t_in_item                  i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output i2cms_pkg::t_out_item                 o_out_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [i2cms_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [15:0]                          i_cfg_data
);

    i2cms_pkg::t_in_item  r_in;
    logic                 r_in_vld;
    i2cms_pkg::t_out_item r_out;
    logic                 r_out_vld;
    i2cms_pkg::t_cfg      r_cfg;
    i2cms_pkg::t_out_item w_res;
    logic                 w_out_free;
    logic                 w_step;

    assign w_out_free  = !r_out_vld || !i_out_stall;
    assign w_step      = r_in_vld && w_out_free;
    assign o_in_stall  = r_in_vld && !w_out_free;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    i2cms_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_cfg.unit_ticks     <= i2cms_pkg::UNIT_TICKS_RESET;
            r_cfg.ack_poll_limit <= i2cms_pkg::ACK_POLL_LIMIT_RESET;
        end else begin
            if (!o_in_stall) begin
                r_in_vld <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_vld <= w_step;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    i2cms_pkg::CFG_UNIT_TICKS:     r_cfg.unit_ticks <= i_cfg_data;
                    i2cms_pkg::CFG_ACK_POLL_LIMIT: r_cfg.ack_poll_limit <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_data;
        end
        if (w_step) begin
            r_out <= w_res;
        end
    end

endmodule
